// File: sv/multi_channel_servo_slew_limiter_defines.svh
// ----------------------------------------------------------------------------
// multi_channel_servo_slew_limiter_defines
// Assertion macros for the servo slew limiter; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_SERVO_SLEW_LIMITER_DEFINES_SVH
`define MULTI_CHANNEL_SERVO_SLEW_LIMITER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define MCSSL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define MCSSL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MCSSL_ASSERT_IMP(lbl, ante, cons, msg)
`define MCSSL_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// File: sv/mcssl_pkg.sv
// ----------------------------------------------------------------------------
// mcssl_pkg
// Types, codes and constants shared by the servo slew limiter modules.
// ----------------------------------------------------------------------------
package mcssl_pkg;

  // request codes
  localparam logic [1:0] REQ_SET    = 2'd0;
  localparam logic [1:0] REQ_PRESET = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  // register indexes
  localparam logic [1:0] CFG_STEP_SIZE  = 2'd0;
  localparam logic [1:0] CFG_PULSE_MIN  = 2'd1;
  localparam logic [1:0] CFG_PULSE_SPAN = 2'd2;

  localparam logic [7:0]  STEP_SIZE_RST  = 8'd27;
  localparam logic [11:0] PULSE_MIN_RST  = 12'd100;
  localparam logic [11:0] PULSE_SPAN_RST = 12'd415;

  localparam logic [7:0]  ANGLE_MAX = 8'd180;
  localparam logic [11:0] PULSE_CAP = 12'd4095;

  // floor(p/180) == (p * DIV_MUL) >> DIV_SHIFT, exact for p < 2^20
  localparam logic [20:0] DIV_MUL   = 21'd1491309;
  localparam int          DIV_SHIFT = 28;

  localparam int CHANNELS_DEF   = 8;
  localparam int FIFO_DEPTH_DEF = 2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] channel;
    logic [7:0] angle;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  out_channel;
    logic [11:0] pulse_count;
    logic        last;
    logic        all_settled;
  } out_item_t;

  // classified command between front and back
  typedef struct packed {
    logic       is_tick;
    logic       is_preset;
    logic [2:0] channel;
    logic [7:0] angle;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  step_size;
    logic [11:0] pulse_min;
    logic [11:0] pulse_span;
  } cfg_t;

endpackage

// File: sv/mcssl_front.sv
// ----------------------------------------------------------------------------
// mcssl_front
// Accepts request beats, drops ignored ones, clamps the angle, registers a cmd.
// ----------------------------------------------------------------------------
module mcssl_front import mcssl_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     cmd_valid,
  input  logic     cmd_ready,
  output cmd_t     cmd
);

  logic [4:0] ch_w;
  logic       in_range;
  logic       keep;
  logic [7:0] ang_clamped;
  logic       hold_v_r, hold_v_nxt;
  cmd_t       hold_r, hold_nxt;

  assign ch_w        = {2'b00, in_data.channel};
  assign in_range    = (ch_w < 5'(CHANNELS));
  assign ang_clamped = (in_data.angle > ANGLE_MAX) ? ANGLE_MAX : in_data.angle;

  always_comb begin
    unique case (in_data.req_type)
      REQ_SET, REQ_PRESET: keep = in_range;
      REQ_TICK:            keep = 1'b1;
      default:             keep = 1'b0;
    endcase
  end

  assign in_ready  = !hold_v_r || cmd_ready;
  assign cmd_valid = hold_v_r;
  assign cmd       = hold_r;

  always_comb begin
    hold_v_nxt = hold_v_r;
    hold_nxt   = hold_r;
    if (in_valid && in_ready) begin
      hold_v_nxt         = keep;
      hold_nxt.is_tick   = (in_data.req_type == REQ_TICK);
      hold_nxt.is_preset = (in_data.req_type == REQ_PRESET);
      hold_nxt.channel   = in_data.channel;
      hold_nxt.angle     = ang_clamped;
    end else if (cmd_ready) begin
      hold_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
  end

endmodule

// File: sv/mcssl_fifo.sv
// ----------------------------------------------------------------------------
// mcssl_fifo
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module mcssl_fifo import mcssl_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push, pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: sv/mcssl_back.sv
// ----------------------------------------------------------------------------
// mcssl_back
// Applies set/preset, sweeps the channels on a tick and computes pulse counts.
// ----------------------------------------------------------------------------
module mcssl_back import mcssl_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_t      cmd,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [7:0]          target_r  [CHANNELS];
  logic [7:0]          current_r [CHANNELS];
  logic [CHANNELS-1:0] diff_r, diff_nxt;
  logic                ticking_r, ticking_nxt;
  logic [CHW-1:0]      idx_r, idx_nxt;
  logic                snap_r, snap_nxt;

  logic           adv, pop, issue, last_ch;
  logic [4:0]     ch_w;
  logic [CHW-1:0] cmd_idx, rd_idx;
  logic [7:0]     cur_rd, tgt_rd, gap, ang_new;
  logic [8:0]     two_step;

  // result pipeline
  logic           s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic [7:0]     s1_ang_r;
  logic [19:0]    s2_prod_r;
  logic [11:0]    s3_quo_r;
  logic [CHW-1:0] s1_idx_r, s2_idx_r, s3_idx_r;
  logic           s1_last_r, s2_last_r, s3_last_r;
  logic           s1_set_r, s2_set_r, s3_set_r;
  logic [40:0]    recip_prod;
  logic [12:0]    pulse_sum;
  logic [4:0]     s3_idx_w;
  out_item_t      out_r;

  assign adv       = !out_v_r || out_ready;
  assign cmd_ready = adv && !ticking_r;
  assign pop       = cmd_valid && cmd_ready;
  assign issue     = ticking_r && adv;
  assign last_ch   = (idx_r == CHW'(CHANNELS - 1));

  assign ch_w    = {2'b00, cmd.channel};
  assign cmd_idx = ch_w[CHW-1:0];
  // current is read at the sweep index while ticking, else at the command's channel
  assign rd_idx  = ticking_r ? idx_r : cmd_idx;
  assign cur_rd  = current_r[rd_idx];
  assign tgt_rd  = target_r[idx_r];

  assign gap      = (tgt_rd > cur_rd) ? tgt_rd - cur_rd : cur_rd - tgt_rd;
  assign two_step = {cfg.step_size, 1'b0};

  always_comb begin
    priority if ({1'b0, gap} <= two_step) begin
      ang_new = tgt_rd;
    end else if (tgt_rd > cur_rd) begin
      ang_new = cur_rd + cfg.step_size;
    end else begin
      ang_new = cur_rd - cfg.step_size;
    end
  end

  always_comb begin
    ticking_nxt = ticking_r;
    idx_nxt     = idx_r;
    snap_nxt    = snap_r;
    diff_nxt    = diff_r;
    if (pop) begin
      if (cmd.is_tick) begin
        ticking_nxt = 1'b1;
        idx_nxt     = '0;
        snap_nxt    = ~|diff_r;
      end else if (cmd.is_preset) begin
        diff_nxt[cmd_idx] = 1'b0;
      end else begin
        diff_nxt[cmd_idx] = (cmd.angle != cur_rd);
      end
    end
    if (issue) begin
      diff_nxt[idx_r] = (ang_new != tgt_rd);
      idx_nxt         = idx_r + 1'b1;
      if (last_ch) begin
        ticking_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticking_r <= 1'b0;
      idx_r     <= '0;
      snap_r    <= 1'b0;
      diff_r    <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        target_r[i]  <= '0;
        current_r[i] <= '0;
      end
    end else begin
      ticking_r <= ticking_nxt;
      idx_r     <= idx_nxt;
      snap_r    <= snap_nxt;
      diff_r    <= diff_nxt;
      if (pop && !cmd.is_tick) begin
        target_r[cmd_idx] <= cmd.angle;
        if (cmd.is_preset) begin
          current_r[cmd_idx] <= cmd.angle;
        end
      end
      if (issue) begin
        current_r[idx_r] <= ang_new;
      end
    end
  end

  assign recip_prod = 41'(s2_prod_r) * 41'(DIV_MUL);
  assign pulse_sum  = {1'b0, s3_quo_r} + {1'b0, cfg.pulse_min};
  assign s3_idx_w   = 5'(s3_idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= issue;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      out_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ang_r  <= ang_new;
      s1_idx_r  <= idx_r;
      s1_last_r <= last_ch;
      s1_set_r  <= snap_r;

      s2_prod_r <= {12'b0, s1_ang_r} * {8'b0, cfg.pulse_span};
      s2_idx_r  <= s1_idx_r;
      s2_last_r <= s1_last_r;
      s2_set_r  <= s1_set_r;

      s3_quo_r  <= recip_prod[DIV_SHIFT +: 12];
      s3_idx_r  <= s2_idx_r;
      s3_last_r <= s2_last_r;
      s3_set_r  <= s2_set_r;

      out_r.out_channel <= s3_idx_w[2:0];
      out_r.pulse_count <= pulse_sum[12] ? PULSE_CAP : pulse_sum[11:0];
      out_r.last        <= s3_last_r;
      out_r.all_settled <= s3_set_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// File: sv/multi_channel_servo_slew_limiter.sv
// ----------------------------------------------------------------------------
// multi_channel_servo_slew_limiter
// Per-channel target/current angles, slewed on each tick into pulse counts.
// ----------------------------------------------------------------------------
// A set or preset beat is applied in the back end and yields no result. A
// tick starts the slew sequencer, which then reads and writes back one
// channel's angles per cycle while the result channel is not stalled, and
// each channel's pulse count passes through the s1, s2, s3 and output
// registers of the multiply / reciprocal-divide pipeline. A stall on
// the result channel holds the sequencer; the two-entry command queue lets the
// front keep taking beats meanwhile. Unused request codes and out-of-range
// channels are dropped at the front.
`include "multi_channel_servo_slew_limiter_defines.svh"

module multi_channel_servo_slew_limiter import mcssl_pkg::*; #(
  parameter int CHANNELS   = CHANNELS_DEF,
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  logic [7:0]  step_r, step_nxt;
  logic [11:0] pmin_r, pmin_nxt;
  logic [11:0] span_r, span_nxt;
  cfg_t        cfg;

  logic f_valid, f_ready, b_valid, b_ready;
  cmd_t f_cmd, b_cmd;

  assign cfg_ready = 1'b1;

  always_comb begin
    step_nxt = step_r;
    pmin_nxt = pmin_r;
    span_nxt = span_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_STEP_SIZE:  step_nxt = cfg_data[7:0];
        CFG_PULSE_MIN:  pmin_nxt = cfg_data;
        CFG_PULSE_SPAN: span_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_SIZE_RST;
      pmin_r <= PULSE_MIN_RST;
      span_r <= PULSE_SPAN_RST;
    end else begin
      step_r <= step_nxt;
      pmin_r <= pmin_nxt;
      span_r <= span_nxt;
    end
  end

  assign cfg.step_size  = step_r;
  assign cfg.pulse_min  = pmin_r;
  assign cfg.pulse_span = span_r;

  mcssl_front #(.CHANNELS(CHANNELS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  mcssl_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_cmd),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_cmd)
  );

  mcssl_back #(.CHANNELS(CHANNELS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd_valid (b_valid),
    .cmd_ready (b_ready),
    .cmd       (b_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // the final beat of a tick always belongs to the highest channel
  `MCSSL_ASSERT_IMP(a_last_chan, out_valid && out_data.last, out_data.out_channel == 3'(CHANNELS - 1), "last beat not on top channel")
  // saturation never drops a count below the floor
  `MCSSL_ASSERT_IMP(a_pulse_floor, out_valid, out_data.pulse_count >= pmin_r, "pulse count below pulse_min")
  // settled flag is one snapshot for the whole tick
  `MCSSL_ASSERT_NXT(a_settled_hold, out_valid && out_ready && !out_data.last, !out_valid || out_data.all_settled == $past(out_data.all_settled), "all_settled changed within a tick")

endmodule
